### rtl/gradient_noise_2d_pcg_macros.svh
// ----------------------------------------------------------------------------
// gradient noise 2d pcg assertion macros
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_2D_PCG_MACROS_SVH
`define GRADIENT_NOISE_2D_PCG_MACROS_SVH
`ifndef SYNTHESIS
`define GN2P_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error(msg);
`define GN2P_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error(msg);
`else
`define GN2P_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define GN2P_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/gn2p_pkg.sv
// ----------------------------------------------------------------------------
// gn2p_pkg
// shared types and constants of the gradient noise block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gn2p_pkg;

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_MULT = 2'd0;
	localparam logic [1:0] REG_INCR = 2'd1;
	localparam logic [1:0] REG_MIX  = 2'd2;

	localparam logic [31:0] MULT_RST = 32'd1664525;
	localparam logic [31:0] INCR_RST = 32'd1013904223;
	localparam logic [31:0] MIX_RST  = 32'd0;

	localparam logic [23:0] GRAD_SPAN = 24'd16777215;
	localparam int ISQ_W = 49;
	localparam logic [ISQ_W-1:0] LEN_FLOOR = 49'd28147494316;
	localparam int ISQ_STEPS = (ISQ_W + 1) / 2;
	localparam int RT_W = 25;
	localparam int Q_W = 17;
	localparam int DIV_STEPS = Q_W;
	localparam int G_W = 18;
	localparam int D_W = 18;
	localparam int CV_W = 20;
	localparam int F_W = 17;
	localparam int CORNER_LAT = 8 + ISQ_STEPS + DIV_STEPS + 3;

	localparam logic [16:0] NORM_Q16 = 17'd46341;
	localparam logic [36:0] FADE_C = 37'd42949672960;
	localparam logic [36:0] FADE_K = 37'd983040;

	localparam int QPTR_W = 2;
	localparam int QUEUE_DEPTH = 1 << QPTR_W;
	localparam logic [QPTR_W:0] QUEUE_FULL_CNT = {1'b1, {QPTR_W{1'b0}}};

	typedef struct packed {
		logic [31:0] mult;
		logic [31:0] incr;
		logic [31:0] mix;
	} cfg_t;

	typedef struct packed {
		logic [31:0] x0;
		logic [31:0] x1;
		logic [31:0] y0;
		logic [31:0] y1;
		logic [15:0] ux;
		logic [15:0] uy;
	} qent_t;

endpackage
`default_nettype wire

### rtl/gn2p_front.sv
// ----------------------------------------------------------------------------
// gn2p_front
// accepts positions, forms lattice corner words and cell offsets
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gn2p_front #(
	parameter int POS_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gn2p_pkg::cfg_t      cfg,
	input  logic                push,
	output logic                full,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic [31:0]         seed,
	output logic                q_wr,
	input  logic                q_full,
	output gn2p_pkg::qent_t     q_data
);
	import gn2p_pkg::*;

	logic                      vld_s1;
	qent_t                     ent_s1;
	qent_t                     ent_d;
	logic [31:0]               lx;
	logic [31:0]               ly;
	logic [31:0]               sy;
	logic [POS_FRAC_BITS+15:0] fx_ext;
	logic [POS_FRAC_BITS+15:0] fy_ext;
	logic                      accept;

	assign lx     = pos_x >>> POS_FRAC_BITS;
	assign ly     = pos_y >>> POS_FRAC_BITS;
	assign sy     = seed ^ cfg.mix;
	assign fx_ext = {pos_x[POS_FRAC_BITS-1:0], 16'd0};
	assign fy_ext = {pos_y[POS_FRAC_BITS-1:0], 16'd0};

	always_comb begin
		ent_d.x0 = lx ^ seed;
		ent_d.x1 = (lx + 32'd1) ^ seed;
		ent_d.y0 = ly ^ sy;
		ent_d.y1 = (ly + 32'd1) ^ sy;
		ent_d.ux = fx_ext[POS_FRAC_BITS+15:POS_FRAC_BITS];
		ent_d.uy = fy_ext[POS_FRAC_BITS+15:POS_FRAC_BITS];
	end

	assign full   = vld_s1 && q_full;
	assign accept = push && !full;
	assign q_wr   = vld_s1 && !q_full;
	assign q_data = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (q_wr) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1 <= ent_d;
		end
	end

endmodule
`default_nettype wire

### rtl/gn2p_queue.sv
// ----------------------------------------------------------------------------
// gn2p_queue
// short first-word-through queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_noise_2d_pcg_macros.svh"
module gn2p_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  gn2p_pkg::qent_t wdata,
	output logic            full,
	input  logic            rd,
	output gn2p_pkg::qent_t rdata,
	output logic            empty
);
	import gn2p_pkg::*;

	qent_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = cnt_q == QUEUE_FULL_CNT;
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	`GN2P_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= QUEUE_FULL_CNT, "queue count over depth")
	`GN2P_ASSERT_IMP(a_no_overrun, clk, arst_n, wr, !full, "write into full queue")
	`GN2P_ASSERT_IMP(a_no_underrun, clk, arst_n, rd, !empty, "read from empty queue")

endmodule
`default_nettype wire

### rtl/gn2p_corner.sv
// ----------------------------------------------------------------------------
// gn2p_corner
// pcg2d hash, gradient normalise and offset dot product for one corner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gn2p_corner (
	input  logic                          clk,
	input  logic                          en,
	input  gn2p_pkg::cfg_t                cfg,
	input  logic [31:0]                   hx,
	input  logic [31:0]                   hy,
	input  logic signed [gn2p_pkg::D_W-1:0]  dx,
	input  logic signed [gn2p_pkg::D_W-1:0]  dy,
	output logic signed [gn2p_pkg::CV_W-1:0] value
);
	import gn2p_pkg::*;

	function automatic logic [31:0] xsh(input logic [31:0] v);
		return v ^ (v >> 16);
	endfunction

	function automatic logic [24:0] grad_raw(input logic [31:0] h);
		logic [24:0] twice;
		logic [24:0] span;
		logic [24:0] diff;
		twice = {h[31:8], 1'b0};
		span  = {1'b0, GRAD_SPAN};
		diff  = h[31] ? twice - span : span - twice;
		return {~h[31], diff[23:0]};
	endfunction

	localparam int DL = CORNER_LAT - 2;

	logic [31:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4, x_s5, y_s5;
	logic        sx_s6, sy_s6, sx_s7, sy_s7, sx_s8, sy_s8;
	logic [23:0] mx_s6, my_s6, mx_s7, my_s7, mx_s8, my_s8;
	logic [47:0] sqx_s7, sqy_s7;
	logic [ISQ_W-1:0] len_s8;
	logic [ISQ_W-1:0] len_sum;
	logic [24:0] gxr, gyr;

	logic signed [D_W-1:0] dlx [DL];
	logic signed [D_W-1:0] dly [DL];

	logic [ISQ_W-1:0] isq_n [ISQ_STEPS];
	logic [ISQ_W-1:0] isq_r [ISQ_STEPS];
	logic [23:0]      isq_mx [ISQ_STEPS];
	logic [23:0]      isq_my [ISQ_STEPS];
	logic             isq_sx [ISQ_STEPS];
	logic             isq_sy [ISQ_STEPS];

	logic [RT_W-1:0] dv_rx [DIV_STEPS];
	logic [RT_W-1:0] dv_ry [DIV_STEPS];
	logic [RT_W-1:0] dv_r  [DIV_STEPS];
	logic [Q_W-1:0]  dv_qx [DIV_STEPS];
	logic [Q_W-1:0]  dv_qy [DIV_STEPS];
	logic            dv_sx [DIV_STEPS];
	logic            dv_sy [DIV_STEPS];

	logic signed [G_W-1:0]   gx_s51, gy_s51;
	logic signed [35:0]      px_s52, py_s52;
	logic signed [36:0]      psum;
	logic signed [CV_W-1:0]  val_s53;

	assign gxr     = grad_raw(xsh(x_s5));
	assign gyr     = grad_raw(xsh(y_s5));
	assign len_sum = {1'b0, sqx_s7} + {1'b0, sqy_s7};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= hx * cfg.mult + cfg.incr;
			y_s1   <= hy * cfg.mult + cfg.incr;
			x_s2   <= x_s1 + y_s1 * cfg.mult;
			y_s2   <= y_s1;
			x_s3   <= x_s2;
			y_s3   <= y_s2 + x_s2 * cfg.mult;
			x_s4   <= xsh(x_s3) + xsh(y_s3) * cfg.mult;
			y_s4   <= xsh(y_s3);
			x_s5   <= x_s4;
			y_s5   <= y_s4 + x_s4 * cfg.mult;
			sx_s6  <= gxr[24];
			mx_s6  <= gxr[23:0];
			sy_s6  <= gyr[24];
			my_s6  <= gyr[23:0];
			sqx_s7 <= mx_s6 * mx_s6;
			sqy_s7 <= my_s6 * my_s6;
			sx_s7  <= sx_s6;
			mx_s7  <= mx_s6;
			sy_s7  <= sy_s6;
			my_s7  <= my_s6;
			len_s8 <= (len_sum < LEN_FLOOR) ? LEN_FLOOR : len_sum;
			sx_s8  <= sx_s7;
			mx_s8  <= mx_s7;
			sy_s8  <= sy_s7;
			my_s8  <= my_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlx[0] <= dx;
			dly[0] <= dy;
			for (int k = 1; k < DL; k++) begin
				dlx[k] <= dlx[k-1];
				dly[k] <= dly[k-1];
			end
		end
	end

	// integer square root, one result bit per stage
	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
		localparam logic [ISQ_W-1:0] BIT = {{(ISQ_W-1){1'b0}}, 1'b1} << (ISQ_W - 1 - 2 * k);
		logic [ISQ_W-1:0] n_in;
		logic [ISQ_W-1:0] r_in;
		logic [ISQ_W-1:0] t;
		logic [23:0]      mx_in, my_in;
		logic             sx_in, sy_in;
		if (k == 0) begin : g_first
			assign n_in  = len_s8;
			assign r_in  = '0;
			assign mx_in = mx_s8;
			assign my_in = my_s8;
			assign sx_in = sx_s8;
			assign sy_in = sy_s8;
		end else begin : g_next
			assign n_in  = isq_n[k-1];
			assign r_in  = isq_r[k-1];
			assign mx_in = isq_mx[k-1];
			assign my_in = isq_my[k-1];
			assign sx_in = isq_sx[k-1];
			assign sy_in = isq_sy[k-1];
		end
		assign t = r_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_in >= t) begin
					isq_n[k] <= n_in - t;
					isq_r[k] <= (r_in >> 1) + BIT;
				end else begin
					isq_n[k] <= n_in;
					isq_r[k] <= r_in >> 1;
				end
				isq_mx[k] <= mx_in;
				isq_my[k] <= my_in;
				isq_sx[k] <= sx_in;
				isq_sy[k] <= sy_in;
			end
		end
	end

	// restoring divide of |a| * 2^16 by the root, one quotient bit per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [RT_W-1:0] rx_in, ry_in, r_in;
		logic [Q_W-1:0]  qx_in, qy_in;
		logic            bx, by, sx_in, sy_in;
		logic [RT_W:0]   shx, shy;
		if (j == 0) begin : g_first
			assign r_in  = isq_r[ISQ_STEPS-1][RT_W-1:0];
			assign rx_in = {2'b00, isq_mx[ISQ_STEPS-1][23:1]};
			assign ry_in = {2'b00, isq_my[ISQ_STEPS-1][23:1]};
			assign bx    = isq_mx[ISQ_STEPS-1][0];
			assign by    = isq_my[ISQ_STEPS-1][0];
			assign qx_in = '0;
			assign qy_in = '0;
			assign sx_in = isq_sx[ISQ_STEPS-1];
			assign sy_in = isq_sy[ISQ_STEPS-1];
		end else begin : g_next
			assign r_in  = dv_r[j-1];
			assign rx_in = dv_rx[j-1];
			assign ry_in = dv_ry[j-1];
			assign bx    = 1'b0;
			assign by    = 1'b0;
			assign qx_in = dv_qx[j-1];
			assign qy_in = dv_qy[j-1];
			assign sx_in = dv_sx[j-1];
			assign sy_in = dv_sy[j-1];
		end
		assign shx = {rx_in, bx};
		assign shy = {ry_in, by};
		always_ff @(posedge clk) begin
			if (en) begin
				if (shx >= {1'b0, r_in}) begin
					dv_rx[j] <= shx[RT_W-1:0] - r_in;
					dv_qx[j] <= {qx_in[Q_W-2:0], 1'b1};
				end else begin
					dv_rx[j] <= shx[RT_W-1:0];
					dv_qx[j] <= {qx_in[Q_W-2:0], 1'b0};
				end
				if (shy >= {1'b0, r_in}) begin
					dv_ry[j] <= shy[RT_W-1:0] - r_in;
					dv_qy[j] <= {qy_in[Q_W-2:0], 1'b1};
				end else begin
					dv_ry[j] <= shy[RT_W-1:0];
					dv_qy[j] <= {qy_in[Q_W-2:0], 1'b0};
				end
				dv_r[j]  <= r_in;
				dv_sx[j] <= sx_in;
				dv_sy[j] <= sy_in;
			end
		end
	end

	assign psum = px_s52 + py_s52;

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s51  <= dv_sx[DIV_STEPS-1] ? -$signed({1'b0, dv_qx[DIV_STEPS-1]})
			                              :  $signed({1'b0, dv_qx[DIV_STEPS-1]});
			gy_s51  <= dv_sy[DIV_STEPS-1] ? -$signed({1'b0, dv_qy[DIV_STEPS-1]})
			                              :  $signed({1'b0, dv_qy[DIV_STEPS-1]});
			px_s52  <= gx_s51 * dlx[DL-1];
			py_s52  <= gy_s51 * dly[DL-1];
			val_s53 <= psum[CV_W+15:16];
		end
	end

	assign value = val_s53;

endmodule
`default_nettype wire

### rtl/gn2p_fade.sv
// ----------------------------------------------------------------------------
// gn2p_fade
// quintic fade of the cell offsets, aligned to the corner pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gn2p_fade (
	input  logic                     clk,
	input  logic                     en,
	input  logic [15:0]              ux,
	input  logic [15:0]              uy,
	output logic [gn2p_pkg::F_W-1:0] fx,
	output logic [gn2p_pkg::F_W-1:0] fy
);
	import gn2p_pkg::*;

	localparam int FD = CORNER_LAT - 3;

	logic [15:0]    dlx [FD];
	logic [15:0]    dly [FD];
	logic [31:0]    uux_s51, uuy_s51;
	logic [15:0]    ux_s51, uy_s51;
	logic [19:0]    inx_s52, iny_s52;
	logic [15:0]    u3x_s52, u3y_s52;
	logic [F_W-1:0] fx_s53, fy_s53;
	logic [36:0]    polx, poly;
	logic [31:0]    u3px, u3py;
	logic [35:0]    fpx, fpy;

	assign polx = {5'd0, uux_s51} * 37'd6 + FADE_C - {21'd0, ux_s51} * FADE_K;
	assign poly = {5'd0, uuy_s51} * 37'd6 + FADE_C - {21'd0, uy_s51} * FADE_K;
	assign u3px = uux_s51[31:16] * ux_s51;
	assign u3py = uuy_s51[31:16] * uy_s51;
	assign fpx  = u3x_s52 * inx_s52;
	assign fpy  = u3y_s52 * iny_s52;

	always_ff @(posedge clk) begin
		if (en) begin
			dlx[0] <= ux;
			dly[0] <= uy;
			for (int k = 1; k < FD; k++) begin
				dlx[k] <= dlx[k-1];
				dly[k] <= dly[k-1];
			end
			uux_s51 <= dlx[FD-1] * dlx[FD-1];
			uuy_s51 <= dly[FD-1] * dly[FD-1];
			ux_s51  <= dlx[FD-1];
			uy_s51  <= dly[FD-1];
			inx_s52 <= polx[35:16];
			iny_s52 <= poly[35:16];
			u3x_s52 <= u3px[31:16];
			u3y_s52 <= u3py[31:16];
			fx_s53  <= fpx[F_W+15:16];
			fy_s53  <= fpy[F_W+15:16];
		end
	end

	assign fx = fx_s53;
	assign fy = fy_s53;

endmodule
`default_nettype wire

### rtl/gradient_noise_2d_pcg.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_pcg
// 2d gradient noise with pcg2d lattice hash, q16.16 in, q1.15 out
//
// channel   dir  handshake            contents
// position  in   push / full          pos_x, pos_y, seed
// noise     out  pop / empty          noise
// config    in   psel/penable/pwrite  hash_multiplier, hash_increment, seed_mix
//
// one position per cycle sustained while results are popped; the delay from accept to result
// on the ports is set by the 25-stage square root and the 17-stage divide of each corner
// a waiting result stalls the back pipeline; the front register and the
// four-entry queue keep taking positions until they fill
// reset empties all stages and loads the register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_noise_2d_pcg_macros.svh"
module gradient_noise_2d_pcg #(
	parameter int POS_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gn2p_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic [31:0]                   seed,
	input  logic                          pop,
	output logic                          empty,
	output logic signed [15:0]            noise
);
	import gn2p_pkg::*;

	localparam int VL = CORNER_LAT + 2;

	function automatic logic signed [CV_W-1:0] lerp16(
		input logic signed [CV_W-1:0] a,
		input logic signed [CV_W-1:0] b,
		input logic [F_W-1:0]         f
	);
		logic signed [CV_W:0]       d;
		logic signed [CV_W+F_W+1:0] p;
		d = $signed({b[CV_W-1], b}) - $signed({a[CV_W-1], a});
		p = d * $signed({1'b0, f});
		return a + $signed(p[CV_W+15:16]);
	endfunction

	cfg_t  cfg_q;
	qent_t q_wdata, q_rdata;
	logic  q_wr, q_full, q_rd, q_empty;
	logic  en;
	logic  vld_s [VL];
	logic  out_v_q;
	logic signed [15:0] noise_q;

	logic signed [CV_W-1:0] cv00, cv10, cv01, cv11;
	logic [F_W-1:0]         fx, fy;
	logic signed [D_W-1:0]  dx0, dx1, dy0, dy1;
	logic signed [CV_W-1:0] l0_s54, l1_s54, v_s55;
	logic [F_W-1:0]         fy_s54;
	logic signed [37:0]     scaled;
	logic signed [20:0]     res;
	logic signed [15:0]     sat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mult <= MULT_RST;
			cfg_q.incr <= INCR_RST;
			cfg_q.mix  <= MIX_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[ADDR_W-1:2])
				REG_MULT: cfg_q.mult <= pwdata;
				REG_INCR: cfg_q.incr <= pwdata;
				REG_MIX:  cfg_q.mix  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_MULT: prdata = cfg_q.mult;
			REG_INCR: prdata = cfg_q.incr;
			REG_MIX:  prdata = cfg_q.mix;
			default:  prdata = '0;
		endcase
	end

	gn2p_front #(
		.POS_FRAC_BITS(POS_FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.full   (full),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.seed   (seed),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_data (q_wdata)
	);

	gn2p_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign en   = !out_v_q || pop;
	assign q_rd = en && !q_empty;

	assign dx0 = $signed({2'b00, q_rdata.ux});
	assign dx1 = $signed({2'b11, q_rdata.ux});
	assign dy0 = $signed({2'b00, q_rdata.uy});
	assign dy1 = $signed({2'b11, q_rdata.uy});

	gn2p_corner u_c00 (
		.clk(clk), .en(en), .cfg(cfg_q), .hx(q_rdata.x0), .hy(q_rdata.y0),
		.dx(dx0), .dy(dy0), .value(cv00)
	);
	gn2p_corner u_c10 (
		.clk(clk), .en(en), .cfg(cfg_q), .hx(q_rdata.x1), .hy(q_rdata.y0),
		.dx(dx1), .dy(dy0), .value(cv10)
	);
	gn2p_corner u_c01 (
		.clk(clk), .en(en), .cfg(cfg_q), .hx(q_rdata.x0), .hy(q_rdata.y1),
		.dx(dx0), .dy(dy1), .value(cv01)
	);
	gn2p_corner u_c11 (
		.clk(clk), .en(en), .cfg(cfg_q), .hx(q_rdata.x1), .hy(q_rdata.y1),
		.dx(dx1), .dy(dy1), .value(cv11)
	);

	gn2p_fade u_fade (
		.clk (clk),
		.en  (en),
		.ux  (q_rdata.ux),
		.uy  (q_rdata.uy),
		.fx  (fx),
		.fy  (fy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VL; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= !q_empty;
			for (int k = 1; k < VL; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign scaled = v_s55 * $signed({1'b0, NORM_Q16});
	assign res    = scaled[37:17];

	always_comb begin
		if (res > 21'sd32767) begin
			sat = 16'sh7fff;
		end else if (res < -21'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = res[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l0_s54 <= lerp16(cv00, cv10, fx);
			l1_s54 <= lerp16(cv01, cv11, fx);
			fy_s54 <= fy;
			v_s55  <= lerp16(l0_s54, l1_s54, fy_s54);
		end
		if (en && vld_s[VL-1]) begin
			noise_q <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= vld_s[VL-1];
		end
	end

	assign empty = !out_v_q;
	assign noise = noise_q;

	`GN2P_ASSERT_IMP(a_issue_moves, clk, arst_n, q_rd, en, "queue read while pipeline held")
	`GN2P_ASSERT_NXT(a_issue_valid, clk, arst_n, q_rd, vld_s[0], "issued item lost at entry")
	`GN2P_ASSERT_NXT(a_result_lands, clk, arst_n, en && vld_s[VL-1], out_v_q, "result dropped")

endmodule
`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// gradient noise 2d pcg testbench
// drives positions and seeds through the push side, pops noise values at
// random rates and checks each against an in-bench fixed-point noise model;
// hash registers are rewritten between phases over the apb port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import gn2p_pkg::*;

	localparam int FRAC = 16;
	localparam longint LIMIT = 600000;

	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] sd;
	} pos_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic signed [31:0] pos_x = '0, pos_y = '0;
	logic [31:0] seed = '0;
	logic pop = 1'b0;
	logic empty;
	logic signed [15:0] noise;

	logic [31:0] mdl_mult = MULT_RST, mdl_incr = INCR_RST, mdl_mix = MIX_RST;
	pos_item_t pending_pos[$];
	logic signed [15:0] expected_noise[$];
	int errors = 0;
	longint cycles = 0;
	bit hold_push = 1'b0;
	int push_gap = 0, pop_gap = 0;

	gradient_noise_2d_pcg #(.POS_FRAC_BITS(FRAC)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic void pcg_hash(inout logic [31:0] x, inout logic [31:0] y);
		x = x * mdl_mult + mdl_incr;
		y = y * mdl_mult + mdl_incr;
		x += y * mdl_mult;
		y += x * mdl_mult;
		x ^= x >> 16;
		y ^= y >> 16;
		x += y * mdl_mult;
		y += x * mdl_mult;
		x ^= x >> 16;
		y ^= y >> 16;
	endfunction

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(longint n);
		longint r, b;
		r = 0;
		b = 64'd1 << 50;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint corner_dot(logic [31:0] cx, logic [31:0] cy, logic [31:0] sd,
			longint dx, longint dy);
		logic [31:0] hx, hy;
		longint ax, ay, s, r, gx, gy;
		hx = cx ^ sd;
		hy = cy ^ sd ^ mdl_mix;
		pcg_hash(hx, hy);
		ax = 2 * longint'(hx >> 8) - 16777215;
		ay = 2 * longint'(hy >> 8) - 16777215;
		s = ax * ax + ay * ay;
		if (s < 64'd28147494316) s = 64'd28147494316;
		r = root_floor(s);
		gx = (ax * 65536) / r;
		gy = (ay * 65536) / r;
		return floor_sh(gx * dx + gy * dy, 16);
	endfunction

	function automatic longint fade_q16(longint u);
		longint inner, u3;
		inner = (6 * u * u + 64'd42949672960 - 983040 * u) >> 16;
		u3 = (((u * u) >> 16) * u) >> 16;
		return (u3 * inner) >> 16;
	endfunction

	function automatic longint blend(longint a, longint b, longint f);
		return a + floor_sh((b - a) * f, 16);
	endfunction

	function automatic logic signed [15:0] noise_of(pos_item_t it);
		logic [31:0] lx, ly;
		longint dx, dy, fx, fy, v, res;
		lx = $signed(it.px) >>> FRAC;
		ly = $signed(it.py) >>> FRAC;
		dx = it.px[15:0];
		dy = it.py[15:0];
		fx = fade_q16(dx);
		fy = fade_q16(dy);
		v = blend(blend(corner_dot(lx, ly, it.sd, dx, dy),
			corner_dot(lx + 1, ly, it.sd, dx - 65536, dy), fx),
			blend(corner_dot(lx, ly + 1, it.sd, dx, dy - 65536),
			corner_dot(lx + 1, ly + 1, it.sd, dx - 65536, dy - 65536), fx), fy);
		res = floor_sh(v * 46341, 17);
		if (res > 32767) res = 32767;
		if (res < -32768) res = -32768;
		return res[15:0];
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		if (push && !full) begin
			expected_noise.push_back(noise_of('{pos_x, pos_y, seed}));
			void'(pending_pos.pop_front());
			push_gap = $urandom_range(0, 6);
		end
		if (push && full) begin
		end else if (arst_n && !hold_push && pending_pos.size() > 0 && push_gap == 0) begin
			push <= 1'b1;
			pos_x <= pending_pos[0].px;
			pos_y <= pending_pos[0].py;
			seed <= pending_pos[0].sd;
		end else begin
			push <= 1'b0;
			if (push_gap > 0) push_gap--;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (pop && !empty) begin
			if (expected_noise.size() == 0) begin
				report("unexpected transaction", noise, 16'h0000);
			end else begin
				if (noise !== expected_noise[0]) report("noise", noise, expected_noise[0]);
				void'(expected_noise.pop_front());
			end
			pop_gap = $urandom_range(0, 6);
		end
		if (pop_gap > 0) begin
			pop <= 1'b0;
			pop_gap--;
		end else begin
			pop <= arst_n;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_MULT: mdl_mult = val;
			REG_INCR: mdl_incr = val;
			REG_MIX: mdl_mix = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_pos.size() > 0 || push || expected_noise.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
			3: return {16'($urandom), 16'($urandom_range(0, 1) ? 16'hffff : 16'h0000)};
			default: return $urandom;
		endcase
	endfunction

	task automatic add_pos(input logic [31:0] x, input logic [31:0] y, input logic [31:0] s);
		pending_pos.push_back('{x, y, s});
	endtask

	initial begin
		logic [31:0] ext[4];
		ext = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		foreach (ext[i]) add_pos(ext[i], ext[3 - i], ext[i]);
		add_pos(32'h0001_8000, 32'hfffe_4000, 32'h1234_5678);
		add_pos(32'h0000_ffff, 32'h0000_0001, 32'hffff_ffff);
		add_pos(32'hffff_0000, 32'h0000_ffff, 32'h0);
		drain();
		// short gradients: a zero multiplier and an increment of 0x80000000 give hash words near the centre
		reg_write(REG_MULT, 32'h0);
		reg_write(REG_INCR, 32'h8000_0000);
		reg_write(REG_MIX, 32'hffff_ffff);
		for (int i = 0; i < 8; i++) add_pos(rnd_word(), rnd_word(), $urandom);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin reg_write(REG_MULT, MULT_RST); reg_write(REG_INCR, INCR_RST);
					reg_write(REG_MIX, MIX_RST); end
				1: begin reg_write(REG_MULT, 32'hffff_ffff); reg_write(REG_INCR, 32'hffff_ffff);
					reg_write(REG_MIX, 32'h0); end
				2: begin reg_write(REG_MULT, 32'h1); reg_write(REG_INCR, 32'h0); end
				default: begin reg_write(REG_MULT, $urandom); reg_write(REG_INCR, $urandom);
					reg_write(REG_MIX, $urandom); end
			endcase
			for (int i = 0; i < 280; i++) begin
				add_pos(rnd_word(), rnd_word(), $urandom_range(0, 3) == 0 ? rnd_word() : $urandom);
				if (ph == 3 && i == 140) begin
					while (pending_pos.size() > 0 || push) @(posedge clk);
					hold_push = 1'b1;
					while (expected_noise.size() > 0) @(posedge clk);
					hold_push = 1'b0;
				end
			end
			drain();
		end
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/gn2p_pkg.sv
rtl/gn2p_front.sv
rtl/gn2p_queue.sv
rtl/gn2p_corner.sv
rtl/gn2p_fade.sv
rtl/gradient_noise_2d_pcg.sv
bench/tb.sv
